@@ hdl/desp_pkg.sv @@
`timescale 1ns / 1ps

package desp_pkg;

   localparam logic [3:0] PH_SEQ_TAG  = 4'd0;
   localparam logic [3:0] PH_SEQ_LEN  = 4'd1;
   localparam logic [3:0] PH_SEQ_LONG = 4'd2;
   localparam logic [3:0] PH_R_TAG    = 4'd3;
   localparam logic [3:0] PH_R_LEN    = 4'd4;
   localparam logic [3:0] PH_R_BODY   = 4'd5;
   localparam logic [3:0] PH_S_TAG    = 4'd6;
   localparam logic [3:0] PH_S_LEN    = 4'd7;
   localparam logic [3:0] PH_S_BODY   = 4'd8;
   localparam logic [3:0] PH_DONE     = 4'd9;

   localparam logic [1:0] KIND_R      = 2'd0;
   localparam logic [1:0] KIND_S      = 2'd1;
   localparam logic [1:0] KIND_REPORT = 2'd2;

   localparam logic [7:0] SEQ_TAG_BYTE  = 8'h30;
   localparam logic [7:0] LONG_LEN_BYTE = 8'h81;
   localparam logic [7:0] INT_TAG_BYTE  = 8'h02;
   localparam logic [7:0] ZERO_BYTE     = 8'h00;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic       has_byte;
      logic [1:0] byte_kind;
      logic [7:0] data;
      logic       has_report;
      logic       status;
      logic [6:0] r_length;
      logic [6:0] s_length;
   } rec_type;

   typedef struct packed {
      logic    push;
      rec_type rec;
   } push_type;

   typedef struct packed {
      logic    full;
      logic    not_empty;
      rec_type head;
   } queue_stat_type;

endpackage

@@ hdl/desp_front.sv @@
`timescale 1ns / 1ps

module desp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              data_byte,
   input  logic                    last_byte,
   output desp_pkg::push_type      push
);

   logic [3:0] phase_ff, phase_in;
   logic [7:0] seq_rem_ff, seq_rem_in;
   logic [6:0] int_rem_ff, int_rem_in;
   logic       strip_ff, strip_in;
   logic [6:0] r_count_ff, r_count_in;
   logic [6:0] s_count_ff, s_count_in;
   logic       failed_ff, failed_in;

   logic [3:0] ph_n;
   logic [7:0] sr_n;
   logic [6:0] ir_n;
   logic       st_n;
   logic [6:0] rc_n, sc_n;
   logic       fl_n;
   logic       emit;
   logic [1:0] emit_kind;
   logic       keep;
   logic [7:0] rem1;
   logic       ok;

   always_comb begin
      ph_n      = phase_ff;
      sr_n      = seq_rem_ff;
      ir_n      = int_rem_ff;
      st_n      = strip_ff;
      rc_n      = r_count_ff;
      sc_n      = s_count_ff;
      fl_n      = failed_ff;
      emit      = 1'b0;
      emit_kind = desp_pkg::KIND_R;
      keep      = 1'b0;
      rem1      = seq_rem_ff - 8'd1;
      if (!failed_ff) begin
         case (phase_ff)
            desp_pkg::PH_SEQ_TAG: begin
               if (data_byte == desp_pkg::SEQ_TAG_BYTE) ph_n = desp_pkg::PH_SEQ_LEN;
               else fl_n = 1'b1;
            end
            desp_pkg::PH_SEQ_LEN: begin
               if (!data_byte[7]) begin
                  sr_n = data_byte;
                  ph_n = desp_pkg::PH_R_TAG;
               end else if (data_byte == desp_pkg::LONG_LEN_BYTE) begin
                  ph_n = desp_pkg::PH_SEQ_LONG;
               end else begin
                  fl_n = 1'b1;
               end
            end
            desp_pkg::PH_SEQ_LONG: begin
               sr_n = data_byte;
               ph_n = desp_pkg::PH_R_TAG;
            end
            desp_pkg::PH_R_TAG, desp_pkg::PH_S_TAG: begin
               if (seq_rem_ff == 8'd0 || data_byte != desp_pkg::INT_TAG_BYTE) begin
                  fl_n = 1'b1;
               end else begin
                  sr_n = rem1;
                  ph_n = (phase_ff == desp_pkg::PH_R_TAG) ? desp_pkg::PH_R_LEN
                                                          : desp_pkg::PH_S_LEN;
               end
            end
            desp_pkg::PH_R_LEN, desp_pkg::PH_S_LEN: begin
               if (seq_rem_ff == 8'd0) begin
                  fl_n = 1'b1;
               end else begin
                  sr_n = rem1;
                  if (data_byte == desp_pkg::ZERO_BYTE || data_byte[7] || data_byte > rem1) begin
                     fl_n = 1'b1;
                  end else begin
                     ir_n = data_byte[6:0];
                     st_n = 1'b1;
                     ph_n = (phase_ff == desp_pkg::PH_R_LEN) ? desp_pkg::PH_R_BODY
                                                             : desp_pkg::PH_S_BODY;
                  end
               end
            end
            desp_pkg::PH_R_BODY, desp_pkg::PH_S_BODY: begin
               if (int_rem_ff == 7'd0 || seq_rem_ff == 8'd0) begin
                  fl_n = 1'b1;
               end else begin
                  keep = !(strip_ff && data_byte == desp_pkg::ZERO_BYTE && int_rem_ff > 7'd1);
                  if (keep) begin
                     st_n = 1'b0;
                     emit = 1'b1;
                     if (phase_ff == desp_pkg::PH_R_BODY) begin
                        rc_n      = r_count_ff + 7'd1;
                        emit_kind = desp_pkg::KIND_R;
                     end else begin
                        sc_n      = s_count_ff + 7'd1;
                        emit_kind = desp_pkg::KIND_S;
                     end
                  end
                  ir_n = int_rem_ff - 7'd1;
                  sr_n = rem1;
                  if (int_rem_ff == 7'd1) begin
                     if (phase_ff == desp_pkg::PH_R_BODY) ph_n = desp_pkg::PH_S_TAG;
                     else if (rem1 != 8'd0) fl_n = 1'b1;
                     else ph_n = desp_pkg::PH_DONE;
                  end
               end
            end
            desp_pkg::PH_DONE: begin
            end
            default: fl_n = 1'b1;
         endcase
      end

      ok = !fl_n && ph_n == desp_pkg::PH_DONE;

      push.push               = accept && (emit || last_byte);
      push.rec.has_byte       = emit;
      push.rec.byte_kind      = emit_kind;
      push.rec.data           = data_byte;
      push.rec.has_report     = last_byte;
      push.rec.status         = !ok;
      push.rec.r_length       = ok ? rc_n : 7'd0;
      push.rec.s_length       = ok ? sc_n : 7'd0;

      if (last_byte) begin
         phase_in   = desp_pkg::PH_SEQ_TAG;
         seq_rem_in = 8'd0;
         int_rem_in = 7'd0;
         strip_in   = 1'b1;
         r_count_in = 7'd0;
         s_count_in = 7'd0;
         failed_in  = 1'b0;
      end else begin
         phase_in   = ph_n;
         seq_rem_in = sr_n;
         int_rem_in = ir_n;
         strip_in   = st_n;
         r_count_in = rc_n;
         s_count_in = sc_n;
         failed_in  = fl_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= desp_pkg::PH_SEQ_TAG;
         seq_rem_ff <= 8'd0;
         int_rem_ff <= 7'd0;
         strip_ff   <= 1'b1;
         r_count_ff <= 7'd0;
         s_count_ff <= 7'd0;
         failed_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         seq_rem_ff <= seq_rem_in;
         int_rem_ff <= int_rem_in;
         strip_ff   <= strip_in;
         r_count_ff <= r_count_in;
         s_count_ff <= s_count_in;
         failed_ff  <= failed_in;
      end
   end

endmodule

@@ hdl/desp_queue.sv @@
`timescale 1ns / 1ps

module desp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  desp_pkg::push_type         push,
   input  logic                       pop,
   output desp_pkg::queue_stat_type   stat
);

   desp_pkg::rec_type             mem_ff [desp_pkg::QUEUE_DEPTH];
   logic [desp_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [desp_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [desp_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   always_comb begin
      do_push   = push.push && (count_ff != (desp_pkg::QUEUE_AW+1)'(desp_pkg::QUEUE_DEPTH));
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{desp_pkg::QUEUE_AW{1'b0}}, do_push}
                           - {{desp_pkg::QUEUE_AW{1'b0}}, do_pop};
      stat.full      = (count_ff == (desp_pkg::QUEUE_AW+1)'(desp_pkg::QUEUE_DEPTH));
      stat.not_empty = (count_ff != '0);
      stat.head      = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.rec;
      end
   end

endmodule

@@ hdl/desp_back.sv @@
`timescale 1ns / 1ps

module desp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  desp_pkg::queue_stat_type   stat,
   output logic                       pop,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_kind,
   output logic [7:0]                 rsp_data_byte_res,
   output logic                       rsp_status,
   output logic [6:0]                 rsp_r_length,
   output logic [6:0]                 rsp_s_length,
   output logic                       rsp_last
);

   logic byte_sent_ff, byte_sent_in;
   logic send_byte;
   logic fire;

   always_comb begin
      send_byte = stat.head.has_byte && !byte_sent_ff;
      rsp_valid = stat.not_empty;
      fire      = rsp_valid && !rsp_stall;
      if (send_byte) begin
         rsp_kind          = stat.head.byte_kind;
         rsp_data_byte_res = stat.head.data;
         rsp_status        = 1'b0;
         rsp_r_length      = 7'd0;
         rsp_s_length      = 7'd0;
         rsp_last          = 1'b0;
      end else begin
         rsp_kind          = desp_pkg::KIND_REPORT;
         rsp_data_byte_res = 8'd0;
         rsp_status        = stat.head.status;
         rsp_r_length      = stat.head.r_length;
         rsp_s_length      = stat.head.s_length;
         rsp_last          = 1'b1;
      end
      pop          = fire && !(send_byte && stat.head.has_report);
      byte_sent_in = byte_sent_ff;
      if (fire) begin
         byte_sent_in = send_byte && stat.head.has_report;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_sent_ff <= 1'b0;
      end else begin
         byte_sent_ff <= byte_sent_in;
      end
   end

endmodule

@@ hdl/der_ecdsa_signature_parser_core.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// req_      in         req_valid / req_stall    data_byte, last_byte
// rsp_      out        rsp_valid / rsp_stall    kind, data_byte_res, status, r_length,
//                                               s_length, last
//
// One input byte per cycle while req_stall is low; the parser state machine updates
// on each transaction. Each byte yields zero, one or two results, queued four deep;
// the output side drains one result per cycle while rsp_stall is low, so a byte that
// ends a signature while keeping an integer byte gives a byte result, then a report.
// Reset clears the parser state and empties the queue.
// req_stall rises only while the queue is full; rsp_stall holds the queue head.

module der_ecdsa_signature_parser_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte_res,
   output logic       rsp_status,
   output logic [6:0] rsp_r_length,
   output logic [6:0] rsp_s_length,
   output logic       rsp_last
);

   desp_pkg::push_type       push;
   desp_pkg::queue_stat_type stat;
   logic                     pop;
   logic                     accept;

   assign req_stall = stat.full;
   assign accept    = req_valid && !stat.full;

   desp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .push      (push)
   );

   desp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .stat  (stat)
   );

   desp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .stat              (stat),
      .pop               (pop),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte_res (rsp_data_byte_res),
      .rsp_status        (rsp_status),
      .rsp_r_length      (rsp_r_length),
      .rsp_s_length      (rsp_s_length),
      .rsp_last          (rsp_last)
   );

endmodule
